[src/pcc_pkg.sv]
`default_nettype none

package pcc_pkg;

  localparam int WINDOW_DEF     = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int TOTAL_BITS = 16;
  localparam int POS_W      = 31;
  localparam int NCODES     = 5;
  localparam int CODE_W     = 3;
  localparam int CMD_W      = 2;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 104;
  localparam int ADDR_W     = 3;
  localparam int CFG_W      = 32;
  localparam int COV_W      = 16;
  localparam int QUAL_W     = 7;

  localparam logic [COV_W-1:0]  COV_RESET  = 16'd2;
  localparam logic [QUAL_W-1:0] QUAL_RESET = 7'd20;

  // quality characters are offset by '!'
  localparam logic [7:0] QUAL_OFFSET = 8'd33;

  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIN_TO  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIN_ALL = 2'd2;

  localparam logic [CODE_W-1:0] CODE_N = 3'd0;
  localparam logic [CODE_W-1:0] CODE_A = 3'd1;
  localparam logic [CODE_W-1:0] CODE_C = 3'd2;
  localparam logic [CODE_W-1:0] CODE_G = 3'd3;
  localparam logic [CODE_W-1:0] CODE_T = 3'd4;

  localparam logic REG_COV  = 1'b0;
  localparam logic REG_QUAL = 1'b1;

  typedef struct packed {
    logic latch_in;
    logic add_eval;
    logic add_write;
    logic fin_setup;
    logic fin_read;
    logic emit_pos;
    logic emit_gap;
    logic fin_finish;
  } pcc_cmd_t;

  typedef struct packed {
    logic add_ok;
    logic fin_go;
    logic walk_more;
    logic gap_needed;
    logic out_free;
  } pcc_stat_t;

  function automatic logic [CODE_W-1:0] code_of(input logic [7:0] c);
    logic [CODE_W-1:0] r;
    case (c)
      "A", "a": r = CODE_A;
      "C", "c": r = CODE_C;
      "G", "g": r = CODE_G;
      "T", "t": r = CODE_T;
      default:  r = CODE_N;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/pcc_ram.sv]
`default_nettype none

module pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/pcc_ctrl.sv]
`default_nettype none

module pcc_ctrl import pcc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [CMD_W-1:0] s_tuser,
  input  wire pcc_stat_t        stat,
  output pcc_cmd_t              cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ADD_RD    = 3'd1;
  localparam logic [2:0] S_ADD_WR    = 3'd2;
  localparam logic [2:0] S_FIN_SETUP = 3'd3;
  localparam logic [2:0] S_FIN_RD    = 3'd4;
  localparam logic [2:0] S_FIN_EMIT  = 3'd5;
  localparam logic [2:0] S_FIN_GAP   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic [2:0] entry_state;

  assign s_tready = (state == S_IDLE) || (state == S_ADD_WR);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    unique case (s_tuser) inside
      CMD_ADD:                 entry_state = S_ADD_RD;
      CMD_FIN_TO, CMD_FIN_ALL: entry_state = S_FIN_SETUP;
      default:                 entry_state = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.latch_in   = accept;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = entry_state;
        end
      end
      S_ADD_RD: begin
        cmd.add_eval = 1'b1;
        state_next   = stat.add_ok ? S_ADD_WR : S_IDLE;
      end
      S_ADD_WR: begin
        cmd.add_write = 1'b1;
        state_next    = accept ? entry_state : S_IDLE;
      end
      S_FIN_SETUP: begin
        cmd.fin_setup = 1'b1;
        state_next    = stat.fin_go ? S_FIN_RD : S_IDLE;
      end
      S_FIN_RD: begin
        cmd.fin_read = 1'b1;
        if (stat.walk_more) begin
          state_next = S_FIN_EMIT;
        end else if (stat.gap_needed) begin
          state_next = S_FIN_GAP;
        end else begin
          cmd.fin_finish = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_FIN_EMIT: begin
        // hold until the output register frees up
        if (stat.out_free) begin
          cmd.emit_pos = 1'b1;
          state_next   = S_FIN_RD;
        end
      end
      S_FIN_GAP: begin
        if (stat.out_free) begin
          cmd.emit_gap   = 1'b1;
          cmd.fin_finish = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[src/pcc_datapath.sv]
`default_nettype none

module pcc_datapath import pcc_pkg::*; #(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pcc_cmd_t          cmd,
  output pcc_stat_t              stat,
  input  wire logic [COV_W-1:0]  cov_thr,
  input  wire logic [QUAL_W-1:0] qual_thr,
  input  wire logic [CMD_W-1:0]  s_tuser,
  input  wire logic [IN_W-1:0]   s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [OUT_W-1:0]  m_tdata,
  output logic                   m_tlast
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int WORD_W = NCODES * COUNT_BITS + TOTAL_BITS;

  // latched input item
  logic [CMD_W-1:0] in_cmd;
  logic [7:0]       in_base;
  logic [7:0]       in_qual;
  logic             in_mapped;
  logic [POS_W-1:0] in_pos;

  // frontier is one bit wider: a full flush past the top position carries out
  logic              started;
  logic [POS_W:0]    frontier;
  logic [POS_W-1:0]  highest;
  logic              overflow_seen;
  logic [SLOT_W-1:0] fslot;
  logic [WINDOW-1:0] slot_valid;

  logic [SLOT_W-1:0] add_slot;
  logic [CODE_W-1:0] add_code;
  logic [POS_W:0]    target_r;
  logic [POS_W:0]    walk_p;
  logic [SLOT_W-1:0] wslot;

  logic             out_valid;
  logic [POS_W-1:0] out_pos;
  logic [CODE_W-1:0] out_code;
  logic [POS_W-1:0] out_gap;
  logic             out_ovf;
  logic [POS_W-1:0] out_front;
  logic             out_last;

  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] ram_wdata;

  // add evaluation
  logic [POS_W:0]    pos_ext;
  logic [POS_W:0]    eff_front;
  logic [POS_W-1:0]  eff_high;
  logic [POS_W:0]    diff;
  logic              qualified;
  logic [7:0]        q_adj;
  logic              in_win;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot_comb;

  assign pos_ext   = {1'b0, in_pos};
  assign eff_front = started ? frontier : pos_ext;
  assign eff_high  = started ? highest : in_pos;
  assign diff      = pos_ext - eff_front;
  assign q_adj     = in_qual - QUAL_OFFSET;
  assign qualified = in_mapped && (in_qual >= QUAL_OFFSET) && (q_adj >= {1'b0, qual_thr});
  assign in_win    = (pos_ext >= eff_front) && (diff < (POS_W+1)'(WINDOW))
                     && (in_pos != {POS_W{1'b1}});
  assign slot_sum  = {1'b0, fslot} + {1'b0, diff[SLOT_W-1:0]};
  assign slot_comb = (slot_sum >= (SLOT_W+1)'(WINDOW))
                     ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW)) : SLOT_W'(slot_sum);

  // finalize target
  logic [POS_W:0] target_comb;
  assign target_comb = (in_cmd == CMD_FIN_TO) ? pos_ext : ({1'b0, highest} + 1'b1);

  // counter update for an add: a slot without its valid bit reads as zero
  logic [WORD_W-1:0] add_word;
  assign add_word = slot_valid[add_slot] ? ram_rdata : '0;

  always_comb begin
    logic [COUNT_BITS-1:0] cnt;
    logic [TOTAL_BITS-1:0] tot;
    ram_wdata = add_word;
    for (int j = 0; j < NCODES; j++) begin
      cnt = add_word[j*COUNT_BITS +: COUNT_BITS];
      if ((add_code == CODE_W'(j)) && (cnt != {COUNT_BITS{1'b1}})) begin
        ram_wdata[j*COUNT_BITS +: COUNT_BITS] = cnt + 1'b1;
      end
    end
    tot = add_word[NCODES*COUNT_BITS +: TOTAL_BITS];
    if (tot != {TOTAL_BITS{1'b1}}) begin
      ram_wdata[NCODES*COUNT_BITS +: TOTAL_BITS] = tot + 1'b1;
    end
  end

  // majority call for the walked slot; earliest code wins a tie
  logic [WORD_W-1:0] call_word;
  logic [CODE_W-1:0] call_code;
  assign call_word = slot_valid[wslot] ? ram_rdata : '0;

  always_comb begin
    logic [COUNT_BITS-1:0] best_cnt;
    logic [CODE_W-1:0]     best;
    best     = CODE_N;
    best_cnt = call_word[COUNT_BITS-1:0];
    for (int j = 1; j < NCODES; j++) begin
      if (call_word[j*COUNT_BITS +: COUNT_BITS] > best_cnt) begin
        best     = CODE_W'(j);
        best_cnt = call_word[j*COUNT_BITS +: COUNT_BITS];
      end
    end
    if (call_word[NCODES*COUNT_BITS +: TOTAL_BITS] < cov_thr) begin
      best = CODE_N;
    end
    call_code = best;
  end

  logic [SLOT_W-1:0] wslot_inc;
  logic [POS_W:0]    walk_p_inc;
  logic [POS_W:0]    gap_len;
  assign wslot_inc  = (wslot == SLOT_W'(WINDOW - 1)) ? '0 : wslot + 1'b1;
  assign walk_p_inc = walk_p + 1'b1;
  assign gap_len    = target_r - walk_p;

  assign stat.add_ok     = qualified && in_win;
  assign stat.fin_go     = started && (target_comb > frontier);
  assign stat.gap_needed = walk_p < target_r;
  assign stat.walk_more  = (walk_p < target_r) && (walk_p <= {1'b0, highest});
  assign stat.out_free   = !out_valid || m_tready;

  assign ram_re    = cmd.add_eval || cmd.fin_read;
  assign ram_raddr = cmd.fin_read ? wslot : slot_comb;

  pcc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WINDOW)
  ) u_counts (
    .clk   (clk),
    .we    (cmd.add_write),
    .waddr (add_slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_cmd    <= s_tuser;
      in_base   <= s_tdata[7:0];
      in_qual   <= s_tdata[15:8];
      in_mapped <= s_tdata[16];
      in_pos    <= s_tdata[47:17];
    end
    if (cmd.add_eval) begin
      add_slot <= slot_comb;
      add_code <= code_of(in_base);
    end
    if (cmd.fin_setup) begin
      target_r <= target_comb;
      walk_p   <= frontier;
      wslot    <= fslot;
    end else if (cmd.emit_pos) begin
      walk_p <= walk_p_inc;
      wslot  <= wslot_inc;
    end
    if (cmd.emit_pos) begin
      out_pos   <= walk_p[POS_W-1:0];
      out_code  <= call_code;
      out_gap   <= '0;
      out_ovf   <= overflow_seen;
      out_front <= target_r[POS_W-1:0];
      out_last  <= (walk_p_inc == target_r);
    end else if (cmd.emit_gap) begin
      out_pos   <= walk_p[POS_W-1:0];
      out_code  <= CODE_N;
      out_gap   <= gap_len[POS_W-1:0];
      out_ovf   <= overflow_seen;
      out_front <= target_r[POS_W-1:0];
      out_last  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      frontier      <= '0;
      highest       <= '0;
      overflow_seen <= 1'b0;
      fslot         <= '0;
      slot_valid    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.add_eval && qualified) begin
        started  <= 1'b1;
        frontier <= eff_front;
        if (!in_win) begin
          overflow_seen <= 1'b1;
          highest       <= eff_high;
        end else begin
          highest <= (in_pos > eff_high) ? in_pos : eff_high;
        end
      end
      if (cmd.add_write) begin
        slot_valid[add_slot] <= 1'b1;
      end
      if (cmd.emit_pos) begin
        slot_valid[wslot] <= 1'b0;
      end
      if (cmd.fin_finish) begin
        frontier <= target_r;
        fslot    <= wslot;
      end
      if (cmd.emit_pos || cmd.emit_gap) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {(OUT_W - 3*POS_W - CODE_W - 1)'(0),
                     out_front, out_ovf, out_gap, out_code, out_pos};

`ifndef SYNTH
  a_frontier_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> frontier >= $past(frontier))
    else $error("frontier moved backward");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_pos |-> walk_p < target_r)
    else $error("walk emitted a position at or past the target");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_pos || cmd.emit_gap) |-> (!out_valid || m_tready))
    else $error("result loaded over an untaken item");

  a_span: assert property (@(posedge clk) disable iff (rst)
    (started && ({1'b0, highest} >= frontier))
      |-> (({1'b0, highest} - frontier) < (POS_W+1)'(WINDOW)))
    else $error("highest counted position left the window");
`endif

endmodule

`default_nettype wire

[src/pileup_consensus_caller_core.sv]
// Pileup consensus caller.
// Input stream s_*: one item per aligned base or command. s_tuser carries the
// command (add base, finalize up to position, finalize all); s_tdata carries
// base, quality, mapped flag and position. An add is a read-modify-write of
// the per-position counter RAM (one read port, one write port): a read state,
// then a write state that can already take the next item. A finalize runs a
// setup state, then a RAM read state and a call-and-emit state per finalized
// position, a closing read state, and a gap state when a trailing gap item is
// emitted. Up to WINDOW + 1 result items per finalize; the last carries
// m_tlast. A finalize that gives no result ends after its setup state; the
// unused command leads to no other state. Output m_* is a single output
// register: when the receiver stalls, the walk holds on the pending position
// and no further input is taken. Reset clears the counter valid bits,
// frontier, overflow flag and the output register at once (no clearing pass),
// and restores the thresholds to their defaults. Thresholds are to be written
// over the APB port only while the block is idle; the block does not check it.
`default_nettype none

module pileup_consensus_caller_core import pcc_pkg::*; #(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // base_char[7:0], quality_char[15:8], base_mapped[16], position[47:17]
  input  wire logic [IN_W-1:0]   s_tdata,
  // command[1:0]
  input  wire logic [CMD_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // out_position[30:0], consensus_code[33:31], gap_length[64:34],
  // window_overflow[65], frontier_position[96:66], zero fill[103:97]
  output logic      [OUT_W-1:0]  m_tdata,
  output logic                   m_tlast,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [CFG_W-1:0]  pwdata,
  output logic      [CFG_W-1:0]  prdata,
  output logic                   pready
);

  logic [COV_W-1:0]  cov_thr;
  logic [QUAL_W-1:0] qual_thr;
  logic              cfg_write;
  pcc_cmd_t          cmd;
  pcc_stat_t         stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cov_thr  <= COV_RESET;
      qual_thr <= QUAL_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_COV:  cov_thr  <= pwdata[COV_W-1:0];
        REG_QUAL: qual_thr <= pwdata[QUAL_W-1:0];
        default:  cov_thr  <= cov_thr;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COV:  prdata = {(CFG_W - COV_W)'(0), cov_thr};
      REG_QUAL: prdata = {(CFG_W - QUAL_W)'(0), qual_thr};
      default:  prdata = '0;
    endcase
  end

  pcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcc_datapath #(
    .WINDOW     (WINDOW),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cov_thr  (cov_thr),
    .qual_thr (qual_thr),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

[tb/sv/tb_pileup_consensus_caller_core.sv]
`timescale 1ns / 100ps

module tb_pileup_consensus_caller_core;
  import pcc_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [POS_W-1:0] POS_TOP = '1;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       base;
    logic [7:0]       qual;
    logic             mapped;
    logic [POS_W-1:0] pos;
  } read_item_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  gap;
    logic              ovf;
    logic [POS_W-1:0]  front;
    logic              last;
  } call_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // base_char[7:0], quality_char[15:8], base_mapped[16], position[47:17]
  logic [IN_W-1:0] s_tdata = '0;
  // command[1:0]
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // out_position[30:0], consensus_code[33:31], gap_length[64:34],
  // window_overflow[65], frontier_position[96:66]
  logic [OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;

  pileup_consensus_caller_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the caller's counters and control state
  logic [COUNT_BITS_DEF-1:0] base_cnt [WIN][NCODES];
  logic [TOTAL_BITS-1:0]     cover_tot [WIN];
  bit                        started_q = 1'b0;
  logic [31:0]               front_q = '0;
  logic [31:0]               high_q = '0;
  bit                        ovf_q = 1'b0;
  logic [COV_W-1:0]          cov_thr = COV_RESET;
  logic [QUAL_W-1:0]         qual_thr = QUAL_RESET;

  read_item_t reads_queued[$];
  call_t      calls_due[$];

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int src_wait = 0;
  int snk_wait = 0;
  int src_mode = 1;
  int snk_mode = 1;
  bit hold_go = 1'b0;
  bit hold_on = 1'b0;
  int mismatches = 0;
  int gen_front = 0;
  int gen_hi = 0;

  initial begin
    for (int s = 0; s < WIN; s++) begin
      cover_tot[s] = '0;
      for (int c = 0; c < NCODES; c++) base_cnt[s][c] = '0;
    end
  end

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 7);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
  endfunction

  // Fold lowercase onto uppercase: only 'x' and 'X' map onto 'X' under this mask
  function automatic logic [CODE_W-1:0] base_code(input logic [7:0] ch);
    logic [7:0] up;
    up = ch & 8'hDF;
    if (up == "A") return CODE_A;
    if (up == "C") return CODE_C;
    if (up == "G") return CODE_G;
    if (up == "T") return CODE_T;
    return CODE_N;
  endfunction

  function automatic logic [CODE_W-1:0] majority(input int slot);
    int best;
    best = 0;
    if (cover_tot[slot] < cov_thr) return CODE_N;
    for (int j = 1; j < NCODES; j++)
      if (base_cnt[slot][j] > base_cnt[slot][best]) best = j;
    return CODE_W'(best);
  endfunction

  task automatic count_base(input logic [7:0] b, input logic [7:0] q, input logic m,
                            input logic [POS_W-1:0] pos);
    logic [CODE_W-1:0] code;
    logic [31:0] p32;
    int slot;
    if (!m || q < QUAL_OFFSET || (q - QUAL_OFFSET) < {1'b0, qual_thr}) return;
    code = base_code(b);
    p32 = {1'b0, pos};
    if (!started_q) begin
      started_q = 1'b1;
      front_q = p32;
      high_q = p32;
    end
    if (p32 < front_q || p32 - front_q >= 32'(WIN) || pos == POS_TOP) begin
      ovf_q = 1'b1;
      return;
    end
    slot = p32 % WIN;
    if (base_cnt[slot][code] != '1) base_cnt[slot][code] += 1'b1;
    if (cover_tot[slot] != '1) cover_tot[slot] += 1'b1;
    if (p32 > high_q) high_q = p32;
  endtask

  task automatic call_consensus(input logic [CMD_W-1:0] cmd, input logic [IN_W-1:0] d);
    logic [POS_W-1:0] pos;
    logic [31:0] tgt, p;
    int slot;
    call_t run[$];
    call_t c;
    pos = d[47:17];
    if (cmd == CMD_ADD) begin
      count_base(d[7:0], d[15:8], d[16], pos);
      return;
    end
    if ((cmd != CMD_FIN_TO && cmd != CMD_FIN_ALL) || !started_q) return;
    tgt = (cmd == CMD_FIN_TO) ? {1'b0, pos} : high_q + 32'd1;
    if (tgt <= front_q) return;
    p = front_q;
    while (p < tgt && p <= high_q) begin
      slot = p % WIN;
      c.pos = p[POS_W-1:0];
      c.code = majority(slot);
      c.gap = '0;
      run.insert(run.size(), c);
      for (int j = 0; j < NCODES; j++) base_cnt[slot][j] = '0;
      cover_tot[slot] = '0;
      p++;
    end
    if (p < tgt) begin
      c.pos = p[POS_W-1:0];
      c.code = CODE_N;
      c.gap = POS_W'(tgt - p);
      run.insert(run.size(), c);
    end
    front_q = tgt;
    foreach (run[k]) begin
      c = run[k];
      c.ovf = ovf_q;
      c.front = front_q[POS_W-1:0];
      c.last = (k == run.size() - 1);
      calls_due.insert(calls_due.size(), c);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    call_t want;
    in_fire <= !rst && s_tvalid && s_tready;
    out_fire <= !rst && m_tvalid && m_tready;
    if (!rst && s_tvalid && s_tready) call_consensus(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      if (calls_due.size() == 0) begin
        $display("%0t: unexpected result, expected none got position %0h", $time,
                 m_tdata[30:0]);
        mismatches++;
      end else begin
        want = calls_due[0];
        calls_due.delete(0);
        check_field("out_position", want.pos, m_tdata[30:0]);
        check_field("consensus_code", want.code, m_tdata[33:31]);
        check_field("gap_length", want.gap, m_tdata[64:34]);
        check_field("window_overflow", want.ovf, m_tdata[65]);
        check_field("frontier_position", want.front, m_tdata[96:66]);
        check_field("last", want.last, m_tlast);
      end
    end
  end

  always @(negedge clk) begin : drive
    read_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else if (s_tvalid && !in_fire) begin
      // hold the item until taken
    end else if (src_wait != 0) begin
      s_tvalid <= 1'b0;
      src_wait <= src_wait - 1;
    end else if (reads_queued.size() != 0) begin
      it = reads_queued[0];
      reads_queued.delete(0);
      s_tvalid <= 1'b1;
      s_tdata <= {it.pos, it.mapped, it.qual, it.base};
      s_tuser <= it.cmd;
      src_wait <= draw_wait(src_mode);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin : receive
    int g;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_on) begin
      m_tready <= 1'b0;
    end else if (snk_wait != 0) begin
      m_tready <= 1'b0;
      snk_wait <= snk_wait - 1;
    end else if (out_fire) begin
      g = draw_wait(snk_mode);
      m_tready <= (g == 0);
      snk_wait <= (g == 0) ? 0 : g - 1;
    end else begin
      m_tready <= (snk_mode == 0) || ($urandom_range(0, 3) != 0);
    end
  end

  // Long receiver stall so the output register fills and the input backs up
  initial begin : recv_hold
    wait (hold_go);
    @(negedge clk);
    hold_on <= 1'b1;
    repeat (300) @(negedge clk);
    hold_on <= 1'b0;
  end

  initial begin : watchdog
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [7:0] b,
                           input logic [7:0] q, input logic m, input logic [POS_W-1:0] p);
    read_item_t it;
    it.cmd = cmd;
    it.base = b;
    it.qual = q;
    it.mapped = m;
    it.pos = p;
    reads_queued.insert(reads_queued.size(), it);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_COV) cov_thr = val[COV_W-1:0];
    else qual_thr = val[QUAL_W-1:0];
  endtask

  // Wait for all items taken and all calls seen, then let trailing adds retire
  task automatic settle();
    while (reads_queued.size() != 0 || s_tvalid || calls_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Add runs clustered just past the frontier, each closed by a finalize or no-op
  task automatic queue_pileup(input int n);
    string letters = "ACGTacgtNnX*";
    int made, nadd, spread, r, p;
    logic [7:0] b, q;
    made = 0;
    while (made < n) begin
      nadd = $urandom_range(1, 10);
      spread = ($urandom_range(0, 3) == 0) ? 33 : $urandom_range(2, 8);
      repeat (nadd) begin
        r = $urandom_range(0, 15);
        if (r == 0) p = gen_front - $urandom_range(1, 6);
        else if (r == 1) p = int'(POS_TOP);
        else p = gen_front + $urandom_range(0, spread);
        b = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                        : letters[$urandom_range(0, letters.len() - 1)];
        q = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(33 + $urandom_range(0, 60));
        push_item(CMD_ADD, b, q, $urandom_range(0, 15) != 0, POS_W'(p));
        if (p >= gen_front && p < gen_front + WIN && p > gen_hi) gen_hi = p;
        made++;
      end
      r = $urandom_range(0, 9);
      b = 8'($urandom);
      q = 8'($urandom);
      if (r < 5) begin
        p = gen_front + $urandom_range(0, 36);
        push_item(CMD_FIN_TO, b, q, $urandom_range(0, 1), POS_W'(p));
        if (p > gen_front) gen_front = p;
      end else if (r < 8) begin
        push_item(CMD_FIN_ALL, b, q, $urandom_range(0, 1), POS_W'($urandom));
        if (gen_hi + 1 > gen_front) gen_front = gen_hi + 1;
      end else if (r == 8) begin
        push_item(CMD_UNUSED, b, q, $urandom_range(0, 1), POS_W'($urandom));
      end else begin
        p = gen_front - $urandom_range(0, 3);
        push_item(CMD_FIN_TO, b, q, $urandom_range(0, 1), POS_W'(p));
      end
      made++;
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Nothing counted yet, so finalizes and the unused command do nothing
    push_item(CMD_FIN_ALL, "A", "I", 1'b1, 31'd5);
    push_item(CMD_FIN_TO, "A", "I", 1'b1, 31'd2000);
    push_item(CMD_UNUSED, "C", "I", 1'b1, 31'd1000);
    // Dropped: unmapped, quality char below '!', quality one under threshold
    push_item(CMD_ADD, "A", "I", 1'b0, 31'd1000);
    push_item(CMD_ADD, "A", 8'h20, 1'b1, 31'd1000);
    push_item(CMD_ADD, "A", 8'd52, 1'b1, 31'd1000);
    // First counted base anchors the window at 1000
    push_item(CMD_ADD, "A", 8'd53, 1'b1, 31'd1000);
    push_item(CMD_ADD, "a", 8'hFF, 1'b1, 31'd1000);
    push_item(CMD_ADD, "C", "I", 1'b1, 31'd1001);
    push_item(CMD_ADD, "c", "I", 1'b1, 31'd1001);
    push_item(CMD_ADD, "G", "I", 1'b1, 31'd1002);
    push_item(CMD_ADD, "T", "I", 1'b1, 31'd1003);
    push_item(CMD_ADD, "X", "I", 1'b1, 31'd1004);
    push_item(CMD_ADD, "n", "I", 1'b1, 31'd1004);
    // Tie between G and C: the earlier code wins
    push_item(CMD_ADD, "G", "I", 1'b1, 31'd1005);
    push_item(CMD_ADD, "C", "I", 1'b1, 31'd1005);
    push_item(CMD_ADD, "t", "I", 1'b1, 31'd1031);
    // Outside the window: below frontier, one past the end, top position
    push_item(CMD_ADD, "A", "I", 1'b1, 31'd0);
    push_item(CMD_ADD, "A", "I", 1'b1, 31'd1032);
    push_item(CMD_ADD, "A", "I", 1'b1, POS_TOP);
    push_item(CMD_FIN_TO, "G", "I", 1'b0, 31'd1003);
    push_item(CMD_FIN_TO, "G", "I", 1'b0, 31'd1003);
    push_item(CMD_FIN_ALL, 8'hFF, 8'hFF, 1'b1, 31'd0);
    push_item(CMD_FIN_TO, 8'h00, 8'h00, 1'b0, 31'd1040);
    push_item(CMD_FIN_ALL, "T", "I", 1'b1, 31'd7);
    gen_front = 1040;
    gen_hi = 1031;
    settle();

    write_reg(REG_COV, 32'd0);
    write_reg(REG_QUAL, 32'd0);
    src_mode = 0;
    snk_mode = 0;
    push_item(CMD_ADD, "A", "!", 1'b1, POS_W'(gen_front));
    push_item(CMD_ADD, "C", 8'd32, 1'b1, POS_W'(gen_front + 1));
    queue_pileup(16);
    settle();

    // Top thresholds: only '~' and up qualify, no position meets the coverage floor
    write_reg(REG_COV, 32'd65535);
    write_reg(REG_QUAL, 32'd93);
    src_mode = 0;
    snk_mode = 1;
    repeat (6) push_item(CMD_ADD, "G", "~", 1'b1, POS_W'(gen_front));
    repeat (3) push_item(CMD_ADD, "T", "~", 1'b1, POS_W'(gen_front));
    push_item(CMD_ADD, "C", "}", 1'b1, POS_W'(gen_front));
    push_item(CMD_ADD, "A", "~", 1'b1, POS_W'(gen_front + 1));
    push_item(CMD_FIN_TO, "A", "~", 1'b1, POS_W'(gen_front + 2));
    gen_front += 2;
    gen_hi = gen_front;
    queue_pileup(6);
    settle();

    write_reg(REG_COV, 32'd1);
    write_reg(REG_QUAL, 32'd30);
    src_mode = 1;
    snk_mode = 1;
    hold_go = 1'b1;
    push_item(CMD_ADD, "A", "I", 1'b1, POS_W'(gen_front));
    push_item(CMD_ADD, "C", "I", 1'b1, POS_W'(gen_front + 9));
    push_item(CMD_ADD, "G", "I", 1'b1, POS_W'(gen_front + 31));
    push_item(CMD_FIN_ALL, "A", "I", 1'b1, 31'd0);
    gen_front += 32;
    gen_hi = gen_front;
    queue_pileup(16);
    settle();

    write_reg(REG_COV, 32'd3);
    write_reg(REG_QUAL, 32'($urandom_range(0, 93)));
    src_mode = 2;
    snk_mode = 1;
    queue_pileup(12);
    settle();

    write_reg(REG_COV, 32'(COV_RESET));
    write_reg(REG_QUAL, 32'(QUAL_RESET));
    src_mode = 1;
    snk_mode = 2;
    queue_pileup(8);
    // Jump the frontier near the top of the position range
    push_item(CMD_FIN_TO, "A", "I", 1'b1, 31'h7FFF_FFE0);
    for (int k = 0; k < 11; k++)
      push_item(CMD_ADD, (k % 3 == 0) ? "T" : "g", "I", 1'b1, 31'h7FFF_FFE0 + 31'(k / 2));
    push_item(CMD_ADD, "A", "I", 1'b1, 31'h7FFF_FFEA);
    push_item(CMD_FIN_ALL, "A", "I", 1'b1, 31'd0);
    push_item(CMD_FIN_TO, "A", "I", 1'b1, POS_TOP);
    push_item(CMD_ADD, "C", "I", 1'b1, POS_TOP);
    push_item(CMD_ADD, "C", "I", 1'b1, 31'd12);
    push_item(CMD_FIN_ALL, "A", "I", 1'b1, POS_TOP);
    settle();
    repeat (24) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pcc_pkg.sv
src/pcc_ram.sv
src/pcc_ctrl.sv
src/pcc_datapath.sv
src/pileup_consensus_caller_core.sv
tb/sv/tb_pileup_consensus_caller_core.sv
